[sv/mnps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Note priority stack package
// Shared field widths, arithmetic constants, the control and status bundles
// between sequencer and datapath, and the note-to-frequency function.
// ----------------------------------------------------------------------------
package mnps_pkg;

    localparam int NOTE_W       = 7;
    localparam int VEL_W        = 7;
    localparam int FREQ_W       = 24;
    localparam int AMP_W        = 16;
    localparam int COUNT_OUT_W  = 5;
    localparam int GAIN_W       = 31;
    localparam int PROD_W       = 2 * GAIN_W;
    localparam int S_DATA_W     = 16;
    localparam int M_DATA_W     = 48;
    localparam int M_USER_W     = 2;

    localparam logic [GAIN_W-1:0] GAIN_FLOOR_Q30 = 31'd10737418;
    localparam logic [GAIN_W-1:0] GAIN_STEP_Q30  = 31'd1113711966;
    localparam logic [AMP_W-1:0]  GAIN_MAX_Q15   = 16'd32768;

    localparam logic OP_NOTE_ON  = 1'b0;
    localparam logic OP_NOTE_OFF = 1'b1;

    typedef struct packed {
        logic load_in;
        logic push;
        logic drop;
        logic mul;
        logic rnd;
        logic gain_set;
        logic walk_init;
        logic walk_cmp;
        logic walk_end;
        logic top_rd;
        logic top_set;
        logic out_load;
    } mnps_cmd_t;

    typedef struct packed {
        logic is_on;
        logic full;
        logic iter_done;
        logic walk_done;
        logic top_ok;
        logic out_busy;
    } mnps_status_t;

    function automatic logic [FREQ_W-1:0] top_octave(input logic [3:0] semi);
        logic [FREQ_W-1:0] f;
        begin
            case (semi)
                4'd0:    f = 24'd8572947;
                4'd1:    f = 24'd9082720;
                4'd2:    f = 24'd9622807;
                4'd3:    f = 24'd10195009;
                4'd4:    f = 24'd10801236;
                4'd5:    f = 24'd11443511;
                4'd6:    f = 24'd12123977;
                4'd7:    f = 24'd12844906;
                4'd8:    f = 24'd13608704;
                4'd9:    f = 24'd14417920;
                4'd10:   f = 24'd15275254;
                4'd11:   f = 24'd16183568;
                default: f = '0;
            endcase
            return f;
        end
    endfunction

    // Octave is note / 12, taken as (note * 43) >> 9, exact for every 7-bit note.
    function automatic logic [FREQ_W-1:0] note_to_freq(input logic [NOTE_W-1:0] note);
        logic [12:0]       oct_prod;
        logic [3:0]        octave;
        logic [NOTE_W-1:0] semi;
        logic [3:0]        sh;
        logic [FREQ_W-1:0] base;
        logic [FREQ_W:0]   sum;
        begin
            oct_prod = 13'(note) * 13'd43;
            octave   = oct_prod[12:9];
            semi     = note - NOTE_W'(octave) * NOTE_W'(12);
            sh       = 4'd10 - octave;
            base     = top_octave(semi[3:0]);
            if (sh == 4'd0)
                return base;
            sum = {1'b0, base} + ((FREQ_W + 1)'(1) << (sh - 4'd1));
            return FREQ_W'(sum >> sh);
        end
    endfunction

endpackage
`default_nettype wire

[sv/mnps_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mnps_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[sv/mnps_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Note priority stack sequencer
// Steps one event through push and gain iteration, stack compaction, or a drop when the stack is full.
// ----------------------------------------------------------------------------
module mnps_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire mnps_pkg::mnps_status_t status,
    output mnps_pkg::mnps_cmd_t        cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_PUSH   = 4'd2;
    localparam logic [3:0] S_LOOP   = 4'd3;
    localparam logic [3:0] S_RND    = 4'd4;
    localparam logic [3:0] S_RD     = 4'd5;
    localparam logic [3:0] S_CMP    = 4'd6;
    localparam logic [3:0] S_TOPRD  = 4'd7;
    localparam logic [3:0] S_TOPSET = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.is_on)
                begin
                    if (status.full)
                    begin
                        cmd.drop   = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_RD;
                end
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if (status.iter_done)
                begin
                    cmd.gain_set = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                cmd.rnd    = 1'b1;
                state_next = S_LOOP;
            end
            S_RD:
            begin
                if (status.walk_done)
                begin
                    cmd.walk_end = 1'b1;
                    state_next   = status.top_ok ? S_TOPRD : S_FINISH;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.walk_cmp = 1'b1;
                state_next   = S_RD;
            end
            S_TOPRD:
            begin
                cmd.top_rd = 1'b1;
                state_next = S_TOPSET;
            end
            S_TOPSET:
            begin
                cmd.top_set = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule
`default_nettype wire

[sv/mnps_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Note priority stack datapath
// Holds the note stack, count, pitch, gain, the gain multiplier and the
// output register.
// ----------------------------------------------------------------------------
module mnps_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mnps_pkg::mnps_cmd_t               cmd,
    output mnps_pkg::mnps_status_t                 status,
    input  wire logic [mnps_pkg::S_DATA_W-1:0]     in_data,
    input  wire logic                              in_user,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [mnps_pkg::M_DATA_W-1:0]     out_data,
    output logic      [mnps_pkg::M_USER_W-1:0]     out_user
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam int NW = mnps_pkg::NOTE_W;
    localparam int VW = mnps_pkg::VEL_W;
    localparam int FW = mnps_pkg::FREQ_W;
    localparam int GW = mnps_pkg::GAIN_W;
    localparam int PW = mnps_pkg::PROD_W;
    localparam int AMW = mnps_pkg::AMP_W;

    logic          op_reg;
    logic [NW-1:0] note_reg;
    logic [VW-1:0] vel_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] w_reg, w_next;
    logic          top_hit_reg, top_hit_next;
    logic [FW-1:0] pitch_reg, pitch_next;
    logic [AMW-1:0] gain_reg, gain_next;
    logic [GW-1:0] g_reg;
    logic [PW-1:0] prod_reg;
    logic [VW-1:0] iter_reg;
    logic          changed_reg, changed_next;
    logic          dropped_reg, dropped_next;
    logic          out_valid_reg, out_valid_next;
    logic [mnps_pkg::M_DATA_W-1:0] out_data_reg;
    logic [mnps_pkg::M_USER_W-1:0] out_user_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [NW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [NW-1:0] ram_rdata;
    logic [CW-1:0] w_dec;
    logic [CW-1:0] r_inc;
    logic          keep;
    logic [PW:0]   rnd_sum;
    logic [GW:0]   q_sum;
    logic [GW-15:0] q_val;
    logic [AMW-1:0] gain_clamped;

    assign w_dec = w_reg - CW'(1);
    assign r_inc = r_reg + CW'(1);
    assign keep  = (ram_rdata != note_reg);

    assign ram_we    = cmd.push || (cmd.walk_cmp && keep);
    assign ram_waddr = cmd.push ? count_reg[AW-1:0] : w_reg[AW-1:0];
    assign ram_wdata = cmd.push ? note_reg : ram_rdata;
    assign ram_raddr = cmd.top_rd ? w_dec[AW-1:0] : r_reg[AW-1:0];

    mnps_ram #(
        .WIDTH (NW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rnd_sum = {1'b0, prod_reg} + (PW + 1)'(64'd1 << 29);
    assign q_sum   = {1'b0, g_reg} + (GW + 1)'(16384);
    assign q_val   = q_sum[GW:15];
    assign gain_clamped = (q_val > (GW - 14)'(mnps_pkg::GAIN_MAX_Q15))
                          ? mnps_pkg::GAIN_MAX_Q15 : AMW'(q_val);

    assign status.is_on     = (op_reg == mnps_pkg::OP_NOTE_ON) && (vel_reg != '0);
    assign status.full      = (count_reg == CW'(STACK_DEPTH));
    assign status.iter_done = (iter_reg >= vel_reg);
    assign status.walk_done = (r_reg == count_reg);
    assign status.top_ok    = top_hit_reg && (w_reg != '0);
    assign status.out_busy  = out_valid_reg && !out_ready;

    always_comb
    begin
        count_next     = count_reg;
        r_next         = r_reg;
        w_next         = w_reg;
        top_hit_next   = top_hit_reg;
        pitch_next     = pitch_reg;
        gain_next      = gain_reg;
        changed_next   = changed_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.load_in)
        begin
            changed_next = 1'b0;
            dropped_next = 1'b0;
        end
        if (cmd.drop)
        begin
            dropped_next = 1'b1;
        end
        if (cmd.push)
        begin
            count_next   = count_reg + CW'(1);
            pitch_next   = mnps_pkg::note_to_freq(note_reg);
            changed_next = 1'b1;
        end
        if (cmd.gain_set)
        begin
            gain_next = gain_clamped;
        end
        if (cmd.walk_init)
        begin
            r_next       = '0;
            w_next       = '0;
            top_hit_next = 1'b0;
        end
        if (cmd.walk_cmp)
        begin
            r_next = r_inc;
            if (keep)
            begin
                w_next = w_reg + CW'(1);
            end
            else if (r_inc == count_reg)
            begin
                top_hit_next = 1'b1;
            end
        end
        if (cmd.walk_end)
        begin
            count_next = w_reg;
        end
        if (cmd.top_set)
        begin
            pitch_next   = mnps_pkg::note_to_freq(ram_rdata);
            changed_next = 1'b1;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pitch_reg     <= '0;
            gain_reg      <= '0;
            out_valid_reg <= 1'b0;
            r_reg         <= '0;
            w_reg         <= '0;
            top_hit_reg   <= 1'b0;
            changed_reg   <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pitch_reg     <= pitch_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
            r_reg         <= r_next;
            w_reg         <= w_next;
            top_hit_reg   <= top_hit_next;
            changed_reg   <= changed_next;
            dropped_reg   <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= in_user;
            note_reg <= in_data[NW-1:0];
            vel_reg  <= in_data[NW+VW-1:NW];
        end
        if (cmd.push)
        begin
            g_reg    <= mnps_pkg::GAIN_FLOOR_Q30;
            iter_reg <= VW'(1);
        end
        if (cmd.mul)
        begin
            prod_reg <= PW'(g_reg) * PW'(mnps_pkg::GAIN_STEP_Q30);
        end
        if (cmd.rnd)
        begin
            g_reg    <= GW'(rnd_sum >> 30);
            iter_reg <= iter_reg + VW'(1);
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {3'b000, mnps_pkg::COUNT_OUT_W'(count_reg), gain_reg, pitch_reg};
            out_user_reg <= {dropped_reg, changed_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

endmodule
`default_nettype wire

[sv/mono_note_priority_stack.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Monophonic last-note priority stack
// Tracks held MIDI notes and gives the pitch and gain of the newest note.
// ----------------------------------------------------------------------------
// The time from the accepted word to a valid result is set by the gain loop for a
// note on, which repeats a multiply and a round step until the count reaches the
// velocity; a dropped note on skips it. A note off walks the stack, then reloads
// the pitch when the newest note went and notes remain; the walk reads one entry per step and rewrites it if kept.
// One event at a time: the next word is taken in the cycle after the result is
// queued, and a stalled output delays the queuing. Reset clears count, pitch, gain and the output valid.
module mono_note_priority_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // note_number, velocity, zero pad
    input  wire logic        s_axis_tuser,  // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [47:0] m_axis_tdata,  // frequency, amplitude, note_count, zero pad
    output logic      [1:0]  m_axis_tuser   // pitch_changed, note_dropped
);

    mnps_pkg::mnps_cmd_t    cmd;
    mnps_pkg::mnps_status_t status;

    mnps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mnps_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule
`default_nettype wire

[sv/mnps_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Note priority stack port checker
// Watches the output stream port of the top level over time.
// ----------------------------------------------------------------------------
module mnps_checker #(
    parameter int STACK_DEPTH = 16
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Output word changed while stalled.");

    a_drop_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("A dropped note also changed the pitch.");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[44:40] == 5'(STACK_DEPTH))
        else $error("Note dropped while the stack was not full.");

    a_change_freq: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[23:0] != 24'd0 && m_axis_tdata[44:40] != 5'd0 ||
            STACK_DEPTH > 31)
        else $error("Pitch changed without a held note.");

endmodule

bind mono_note_priority_stack mnps_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
